### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/wsvd_pkg.sv
// ----------------------------------------------------------------------------
// wsvd_pkg
// widths, constants and state types of the window slope valley detector
// ----------------------------------------------------------------------------
`default_nettype none

package wsvd_pkg;

    localparam int WINDOW          = 120;
    localparam int SAMPLE_W        = 16;
    localparam int SLOPE_W         = 33;
    localparam int FRAC_W          = 16;
    localparam int MIN_FIT         = 2;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd500;

    // sample count, window index
    localparam int NW   = $clog2(WINDOW + 1);
    localparam int IW   = $clog2(WINDOW);
    // running sums: sum y, sum x, sum x*y, sum x*x
    localparam int SYW  = SAMPLE_W + NW;
    localparam int SXW  = $clog2(WINDOW * (WINDOW + 1) / 2 + 1);
    localparam int SXYW = SAMPLE_W + SXW;
    localparam int SX2W = $clog2(WINDOW * (WINDOW + 1) * (2 * WINDOW + 1) / 6 + 1);
    localparam int NSQW = 2 * NW;
    // products and the scaled dividend
    localparam int PW   = NW + SXW + SAMPLE_W;
    localparam int DW   = PW + FRAC_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_SIGN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SAT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        M_NSXY,
        M_SXSY,
        M_NSX2,
        M_SXSX
    } t_mstep;

endpackage

`default_nettype wire

### rtl/wsvd_if.sv
// ----------------------------------------------------------------------------
// wsvd_if
// valid/ready channels of the window slope valley detector
// ----------------------------------------------------------------------------
`default_nettype none

interface wsvd_sample_if;
    import wsvd_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_mv;
    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

interface wsvd_result_if;
    import wsvd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      slope_valid;
    logic signed [SLOPE_W-1:0] slope_q16;
    logic                      valley_found;
    modport source (output valid, output slope_valid, output slope_q16,
                    output valley_found, input ready);
    modport sink   (input valid, input slope_valid, input slope_q16,
                    input valley_found, output ready);
endinterface

interface wsvd_cfg_if;
    import wsvd_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] threshold_mv;
    modport source (output valid, output threshold_mv, input ready);
    modport sink   (input valid, input threshold_mv, output ready);
endinterface

`default_nettype wire

### rtl/wsvd_ram.sv
// ----------------------------------------------------------------------------
// wsvd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wsvd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 120
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/wsvd_mul.sv
// ----------------------------------------------------------------------------
// wsvd_mul
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wsvd_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wsvd_pkg::SXW-1:0]    i_mplier,
    input  wire logic [wsvd_pkg::PW-1:0]     i_mcand,
    output logic      [wsvd_pkg::PW-1:0]     o_product,
    output logic                             o_done
);
    import wsvd_pkg::*;

    localparam int CW = $clog2(SXW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SXW-1:0] r_mplier;
    logic [PW-1:0]  r_mcand;
    logic [PW-1:0]  r_acc;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SXW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mplier <= i_mplier;
            r_mcand  <= i_mcand;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mplier <= r_mplier >> 1;
            r_mcand  <= r_mcand << 1;
        end
    end

    assign o_product = r_acc;
    assign o_done    = r_done;

endmodule

`default_nettype wire

### rtl/wsvd_div.sv
// ----------------------------------------------------------------------------
// wsvd_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wsvd_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [wsvd_pkg::DW-1:0]    i_dividend,
    input  wire logic [wsvd_pkg::PW-1:0]    i_divisor,
    output logic      [wsvd_pkg::DW-1:0]    o_quotient,
    output logic                            o_done
);
    import wsvd_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dq;
    logic [PW-1:0] r_rem;
    logic [PW-1:0] r_den;

    logic [PW:0]   w_trial;
    logic [PW:0]   w_diff;
    logic          w_fit;

    // partial remainder with the next dividend bit brought down
    assign w_trial = {r_rem, r_dq[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[PW-1:0] : w_trial[PW-1:0];
            r_dq  <= {r_dq[DW-2:0], w_fit};
        end
    end

    assign o_quotient = r_dq;
    assign o_done     = r_done;

endmodule

`default_nettype wire

### rtl/window_slope_valley_detector_top.sv
// ----------------------------------------------------------------------------
// window_slope_valley_detector_top
// sliding-window least-squares slope with valley flag
// ----------------------------------------------------------------------------
// Every sample beat yields exactly one result beat. Each sample enters a
// window of the last WINDOW samples held in a ram; running sums of y and x*y
// (and of x and x*x while the window fills) are updated in place, reading the
// dropped sample back from the ram. A sample at or below the threshold, or
// one that leaves fewer than two samples in the window, skips the multiplier
// and divider and goes from the update state straight to the output state.
// A sample above the threshold runs four products through one bit-serial
// multiplier and one quotient through a bit-serial divider; these two loops
// set most of its processing time. Only one sample is in work at a time; the
// next one is taken as soon as the result sits in the output register, even
// if that register is still waiting to be taken.
// The threshold may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module window_slope_valley_detector_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wsvd_sample_if.sink  i_sample,
    wsvd_result_if.source o_result,
    wsvd_cfg_if.sink     i_cfg
);
    import wsvd_pkg::*;

    // ring index advance
    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        logic [IW-1:0] nxt;
        if (idx == IW'(WINDOW - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + IW'(1);
        end
        return nxt;
    endfunction

    // control state
    t_state           r_state;
    t_state           n_state;
    t_mstep           r_mstep;
    logic [SAMPLE_W-1:0] r_thr;
    logic [IW-1:0]    r_oldest;
    logic [IW-1:0]    r_newest;
    logic [NW-1:0]    r_fill;
    logic [SYW-1:0]   r_sy;
    logic [SXW-1:0]   r_sx;
    logic [SXYW-1:0]  r_sxy;
    logic [SX2W-1:0]  r_sx2;
    logic             r_prev_neg;
    logic             r_ovalid;

    // per-sample working registers
    logic [SAMPLE_W-1:0] r_sample;
    logic [NW-1:0]    r_n;
    logic             r_full;
    logic [SYW-1:0]   r_ny;
    logic [NSQW-1:0]  r_nsq;
    logic [PW-1:0]    r_pa;
    logic [PW-1:0]    r_pb;
    logic [PW-1:0]    r_pc;
    logic [PW-1:0]    r_den;
    logic             r_neg;
    logic             r_res_valid;
    logic [SLOPE_W-1:0] r_res_slope;
    logic             r_res_valley;

    // output register
    logic             r_o_slope_valid;
    logic [SLOPE_W-1:0] r_o_slope;
    logic             r_o_valley;

    // decoded controls
    logic             w_in_ready;
    logic             w_mul_start;
    logic             w_div_start;
    logic             w_ram_we;
    logic             w_out_load;

    // datapath wires
    logic [NW-1:0]    w_n_calc;
    logic [SAMPLE_W-1:0] w_y0;
    logic [IW-1:0]    w_wr_idx;
    logic             w_hit;
    logic             w_short;
    logic [SXW-1:0]   w_mplier;
    logic [PW-1:0]    w_mcand;
    logic [PW-1:0]    w_product;
    logic             w_mul_done;
    logic [DW-1:0]    w_quot;
    logic             w_div_done;
    logic             w_q_nz;
    logic             w_pos_sat;
    logic             w_neg_sat;
    logic [SLOPE_W-1:0] w_mag_q;
    logic [SLOPE_W-1:0] w_slope;

    assign w_n_calc = (r_fill == NW'(WINDOW)) ? r_fill : r_fill + NW'(1);
    assign w_wr_idx = idx_inc(r_newest);
    assign w_hit    = (r_sample > r_thr);
    assign w_short  = (r_n < NW'(MIN_FIT));

    // window store, read port parked on the oldest entry
    wsvd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_wr_idx),
        .i_wdata (r_sample),
        .i_raddr (r_oldest),
        .o_rdata (w_y0)
    );

    // operand selection for the four products
    always_comb begin
        unique case (r_mstep)
            M_NSXY: begin
                w_mplier = SXW'(r_fill);
                w_mcand  = PW'(r_sxy);
            end
            M_SXSY: begin
                w_mplier = r_sx;
                w_mcand  = PW'(r_sy);
            end
            M_NSX2: begin
                w_mplier = SXW'(r_fill);
                w_mcand  = PW'(r_sx2);
            end
            M_SXSX: begin
                w_mplier = r_sx;
                w_mcand  = PW'(r_sx);
            end
        endcase
    end

    wsvd_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mplier  (w_mplier),
        .i_mcand   (w_mcand),
        .o_product (w_product),
        .o_done    (w_mul_done)
    );

    // numerator magnitude scaled by the 16 fraction bits
    wsvd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_pa, {FRAC_W{1'b0}}}),
        .i_divisor  (r_den),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    // saturation to the 33-bit signed range
    assign w_q_nz    = (w_quot != '0);
    assign w_pos_sat = |w_quot[DW-1:SLOPE_W-1];
    assign w_neg_sat = (|w_quot[DW-1:SLOPE_W])
                    || (w_quot[SLOPE_W-1] && (|w_quot[SLOPE_W-2:0]));
    always_comb begin
        if (r_neg) begin
            w_mag_q = w_neg_sat ? {1'b1, {(SLOPE_W-1){1'b0}}} : w_quot[SLOPE_W-1:0];
            w_slope = SLOPE_W'(0) - w_mag_q;
        end else begin
            w_mag_q = w_pos_sat ? {1'b0, {(SLOPE_W-1){1'b1}}} : w_quot[SLOPE_W-1:0];
            w_slope = w_mag_q;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sample.valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!w_hit || w_short) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                n_state = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (w_mul_done) begin
                    n_state = (r_mstep == M_SXSX) ? S_SIGN : S_MUL_GO;
                end
            end
            S_SIGN: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_result.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state decode
    always_comb begin
        w_in_ready  = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_ram_we    = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE:     w_in_ready  = 1'b1;
            S_UPDATE:   w_ram_we    = 1'b1;
            S_MUL_GO:   w_mul_start = 1'b1;
            S_DIV_GO:   w_div_start = 1'b1;
            S_OUT:      w_out_load  = !r_ovalid || o_result.ready;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mstep    <= M_NSXY;
            r_thr      <= THRESHOLD_RESET;
            r_oldest   <= '0;
            r_newest   <= IW'(WINDOW - 1);
            r_fill     <= '0;
            r_sy       <= '0;
            r_sx       <= '0;
            r_sxy      <= '0;
            r_sx2      <= '0;
            r_prev_neg <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // threshold write beat
            if (i_cfg.valid) begin
                r_thr <= i_cfg.threshold_mv;
            end

            // window bookkeeping and running sums
            if (r_state == S_UPDATE) begin
                r_newest <= w_wr_idx;
                r_fill   <= r_n;
                if (r_full) begin
                    // oldest sample leaves, every x moves down by one
                    r_oldest <= idx_inc(r_oldest);
                    r_sy     <= r_sy - SYW'(w_y0) + SYW'(r_sample);
                    r_sxy    <= r_sxy - SXYW'(r_sy) + SXYW'(r_ny);
                end else begin
                    r_sy  <= r_sy + SYW'(r_sample);
                    r_sxy <= r_sxy + SXYW'(r_ny);
                    r_sx  <= r_sx + SXW'(r_n);
                    r_sx2 <= r_sx2 + SX2W'(r_nsq);
                end
                // a single sample counts as a zero slope
                if (w_hit && w_short) begin
                    r_prev_neg <= 1'b0;
                end
                r_mstep <= M_NSXY;
            end

            if (r_state == S_MUL_WAIT && w_mul_done) begin
                unique case (r_mstep)
                    M_NSXY: r_mstep <= M_SXSY;
                    M_SXSY: r_mstep <= M_NSX2;
                    M_NSX2: r_mstep <= M_SXSX;
                    M_SXSX: r_mstep <= M_NSXY;
                endcase
            end

            if (r_state == S_SAT) begin
                r_prev_neg <= r_neg && w_q_nz;
            end

            // output register occupancy
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_sample.valid) begin
            r_sample <= i_sample.sample_mv;
        end

        if (r_state == S_READ) begin
            r_n    <= w_n_calc;
            r_full <= (r_fill == NW'(WINDOW));
            r_ny   <= SYW'(w_n_calc) * SYW'(r_sample);
            r_nsq  <= NSQW'(w_n_calc) * NSQW'(w_n_calc);
        end

        if (r_state == S_UPDATE) begin
            r_res_valid  <= w_hit;
            r_res_slope  <= '0;
            r_res_valley <= 1'b0;
        end

        if (r_state == S_MUL_WAIT && w_mul_done) begin
            unique case (r_mstep)
                M_NSXY: r_pa  <= w_product;
                M_SXSY: r_pb  <= w_product;
                M_NSX2: r_pc  <= w_product;
                M_SXSX: r_den <= r_pc - w_product;
            endcase
        end

        // numerator n*sxy - sx*sy as sign and magnitude
        if (r_state == S_SIGN) begin
            if (r_pa >= r_pb) begin
                r_pa  <= r_pa - r_pb;
                r_neg <= 1'b0;
            end else begin
                r_pa  <= r_pb - r_pa;
                r_neg <= 1'b1;
            end
        end

        if (r_state == S_SAT) begin
            r_res_slope  <= w_slope;
            r_res_valley <= !r_neg && w_q_nz && r_prev_neg;
        end

        if (w_out_load) begin
            r_o_slope_valid <= r_res_valid;
            r_o_slope       <= r_res_slope;
            r_o_valley      <= r_res_valley;
        end
    end

    assign i_sample.ready        = w_in_ready;
    assign i_cfg.ready           = 1'b1;
    assign o_result.valid        = r_ovalid;
    assign o_result.slope_valid  = r_o_slope_valid;
    assign o_result.slope_q16    = $signed(r_o_slope);
    assign o_result.valley_found = r_o_valley;

endmodule

`default_nettype wire

### rtl/wsvd_checker.sv
// ----------------------------------------------------------------------------
// wsvd_checker
// port-level assertions for the window slope valley detector
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsvd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_slope_valid,
    input wire logic [32:0] i_slope_q16,
    input wire logic        i_valley_found
);

    // a sample beat keeps the block busy for at least the next cycle
    `ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // no slope means an all-zero result
    `ASSERT_IMPL(a_zero_when_invalid, i_clk, i_rst_n, i_out_valid && !i_slope_valid, (i_slope_q16 == 33'd0) && !i_valley_found)

    // a valley needs a valid, strictly positive slope
    `ASSERT_IMPL(a_valley_positive, i_clk, i_rst_n, i_out_valid && i_valley_found, i_slope_valid && !i_slope_q16[32] && (i_slope_q16 != 33'd0))

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_slope_q16) && $stable(i_valley_found) && $stable(i_slope_valid))

endmodule

bind window_slope_valley_detector_top wsvd_checker u_wsvd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_sample.valid),
    .i_in_ready     (i_sample.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_slope_valid  (o_result.slope_valid),
    .i_slope_q16    (o_result.slope_q16),
    .i_valley_found (o_result.valley_found)
);

`default_nettype wire
